// ===== rtl/trin_pkg.sv =====
// Shared types, widths and register codes for the trinomial tree pricer.
`default_nettype none

package trin_pkg;

   localparam int MAX_STEPS_DEF = 1024;
   localparam int PRICE_W       = 48;
   localparam int FACT_W        = 40;
   localparam int PROB_W        = 33;
   localparam int STEPS_W       = 11;
   localparam int ACC_W         = 96;

   localparam logic [PROB_W-1:0] ONE_Q32  = 33'h1_0000_0000;
   localparam logic [ACC_W-1:0]  HALF_LSB = 96'h8000_0000;

   // register codes (paddr[5:3])
   localparam logic [2:0] REG_NUM_STEPS  = 3'd0;
   localparam logic [2:0] REG_PROB_UP    = 3'd1;
   localparam logic [2:0] REG_PROB_DOWN  = 3'd2;
   localparam logic [2:0] REG_UP_FACTOR  = 3'd3;
   localparam logic [2:0] REG_LOW_FACTOR = 3'd4;
   localparam logic [2:0] REG_DISCOUNT   = 3'd5;

   typedef struct packed {
      logic [STEPS_W-1:0] num_steps;
      logic [PROB_W-1:0]  prob_up;
      logic [PROB_W-1:0]  prob_down;
      logic [FACT_W-1:0]  up_factor;
      logic [FACT_W-1:0]  lowest_node_factor;
      logic [PROB_W-1:0]  discount_factor;
   } cfg_type;

   typedef struct packed {
      logic               go;
      logic               clear;
      logic [PRICE_W-1:0] a;
      logic [FACT_W-1:0]  b;
   } mac_cmd_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] acc;
   } mac_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/trinomial_tree_option_pricer.sv =====
// Top level: register file on the APB-style port and the pricing sequencer.
//
//  channel   handshake                        word
//  --------  -------------------------------  ------------------------------------------
//  request   start & !busy                    req_forward_price, req_strike_price,
//                                             req_option_kind
//  response  rsp_valid, one cycle             rsp_option_price, rsp_overflow
//  config    psel & penable & pwrite & pready num_steps .. discount_factor at 8*index
//
//  One item at a time; busy stays high until the cycle its word is presented.
//  An item runs the payoff fill of 2N+1 nodes, N*N node updates and the discount;
//  each update runs three products through the single 32x32 multiply-accumulate
//  unit, four partials each.
//  Reset is synchronous; the node RAM needs no clearing pass.
//  The response is a strobe: the receiver cannot stall it.
`default_nettype none

module trinomial_tree_option_pricer #(
   parameter int MAX_STEPS = trin_pkg::MAX_STEPS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [trin_pkg::PRICE_W-1:0] req_forward_price,
   input  wire logic [trin_pkg::PRICE_W-1:0] req_strike_price,
   input  wire logic                         req_option_kind,
   output logic                              rsp_valid,
   output logic      [trin_pkg::PRICE_W-1:0] rsp_option_price,
   output logic                              rsp_overflow,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [5:0]                   paddr,
   input  wire logic [63:0]                  pwdata,
   output logic      [63:0]                  prdata,
   output logic                              pready
);

   trin_pkg::cfg_type cfg_ff;
   logic              wr_stb;

   assign pready = 1'b1;
   assign wr_stb = psel && penable && pwrite && pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_steps          <= 11'd1;
         cfg_ff.prob_up            <= '0;
         cfg_ff.prob_down          <= '0;
         cfg_ff.up_factor          <= 40'h01_0000_0000;
         cfg_ff.lowest_node_factor <= 40'h01_0000_0000;
         cfg_ff.discount_factor    <= trin_pkg::ONE_Q32;
      end else if (wr_stb) begin
         case (paddr[5:3])
            trin_pkg::REG_NUM_STEPS:  cfg_ff.num_steps          <= pwdata[10:0];
            trin_pkg::REG_PROB_UP:    cfg_ff.prob_up            <= pwdata[32:0];
            trin_pkg::REG_PROB_DOWN:  cfg_ff.prob_down          <= pwdata[32:0];
            trin_pkg::REG_UP_FACTOR:  cfg_ff.up_factor          <= pwdata[39:0];
            trin_pkg::REG_LOW_FACTOR: cfg_ff.lowest_node_factor <= pwdata[39:0];
            trin_pkg::REG_DISCOUNT:   cfg_ff.discount_factor    <= pwdata[32:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (paddr[5:3])
         trin_pkg::REG_NUM_STEPS:  prdata = {53'b0, cfg_ff.num_steps};
         trin_pkg::REG_PROB_UP:    prdata = {31'b0, cfg_ff.prob_up};
         trin_pkg::REG_PROB_DOWN:  prdata = {31'b0, cfg_ff.prob_down};
         trin_pkg::REG_UP_FACTOR:  prdata = {24'b0, cfg_ff.up_factor};
         trin_pkg::REG_LOW_FACTOR: prdata = {24'b0, cfg_ff.lowest_node_factor};
         trin_pkg::REG_DISCOUNT:   prdata = {31'b0, cfg_ff.discount_factor};
         default:                  prdata = '0;
      endcase
   end

   trin_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .start         (start),
      .forward_price (req_forward_price),
      .strike_price  (req_strike_price),
      .option_kind   (req_option_kind),
      .busy          (busy),
      .done          (rsp_valid),
      .option_price  (rsp_option_price),
      .overflow      (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== rtl/trin_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trin_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2049
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/trin_mac.sv =====
// Multiply-accumulate unit: 48x40 product from four 32x32 partials, 96-bit sum.
`default_nettype none

module trin_mac (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trin_pkg::mac_cmd_type cmd,
   output trin_pkg::mac_rsp_type      rsp
);

   logic [trin_pkg::PRICE_W-1:0] a_ff;
   logic [trin_pkg::FACT_W-1:0]  b_ff;
   logic                         run_ff;
   logic [1:0]                   part_ff;
   logic                         first_ff;
   logic                         pvalid_ff;
   logic                         plast_ff;
   logic                         pfirst_ff;
   logic [1:0]                   pshift_ff;
   logic [63:0]                  prod_ff;
   logic                         done_ff;
   logic [trin_pkg::ACC_W-1:0]   acc_ff;

   logic [31:0]                  a_op;
   logic [31:0]                  b_op;
   logic [63:0]                  prod_in;
   logic [trin_pkg::ACC_W-1:0]   shifted;
   logic [trin_pkg::ACC_W-1:0]   acc_in;

   // select operand chunks: low 32 bits or the top part
   always_comb begin
      a_op    = part_ff[1] ? {16'b0, a_ff[47:32]} : a_ff[31:0];
      b_op    = part_ff[0] ? {24'b0, b_ff[39:32]} : b_ff[31:0];
      prod_in = a_op * b_op;
   end

   // align the registered partial and add; a cleared sum starts at half an LSB
   always_comb begin
      case (pshift_ff)
         2'd0:    shifted = {32'b0, prod_ff};
         2'd1:    shifted = {prod_ff, 32'b0};
         2'd2:    shifted = {prod_ff[31:0], 64'b0};
         default: shifted = '0;
      endcase
      acc_in = (pfirst_ff ? trin_pkg::HALF_LSB : acc_ff) + shifted;
   end

   // issue partials
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         pvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         pvalid_ff <= run_ff;
         done_ff   <= pvalid_ff && plast_ff;
         if (cmd.go) begin
            run_ff <= 1'b1;
         end else if (run_ff && part_ff == 2'd3) begin
            run_ff <= 1'b0;
         end
      end
   end

   // operand and partial payload
   always_ff @(posedge clock) begin
      if (cmd.go) begin
         a_ff     <= cmd.a;
         b_ff     <= cmd.b;
         part_ff  <= 2'd0;
         first_ff <= cmd.clear;
      end else if (run_ff) begin
         part_ff <= part_ff + 2'd1;
      end
      prod_ff   <= prod_in;
      pshift_ff <= {1'b0, part_ff[1]} + {1'b0, part_ff[0]};
      plast_ff  <= part_ff == 2'd3;
      pfirst_ff <= first_ff && part_ff == 2'd0;
      if (pvalid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.acc  = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/trin_ctrl.sv =====
// Sequencer: terminal payoff fill, backward induction over the node RAM, discount.
`default_nettype none

module trin_ctrl #(
   parameter int MAX_STEPS = trin_pkg::MAX_STEPS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire trin_pkg::cfg_type            cfg,
   input  wire logic                         start,
   input  wire logic [trin_pkg::PRICE_W-1:0] forward_price,
   input  wire logic [trin_pkg::PRICE_W-1:0] strike_price,
   input  wire logic                         option_kind,
   output logic                              busy,
   output logic                              done,
   output logic      [trin_pkg::PRICE_W-1:0] option_price,
   output logic                              overflow
);

   localparam int DEPTH = 2 * MAX_STEPS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(MAX_STEPS + 1);
   localparam int CW    = (NW > trin_pkg::STEPS_W) ? NW : trin_pkg::STEPS_W;
   localparam int PW    = trin_pkg::PRICE_W;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_FILL  = 14'b00000000000010,
      ST_LV0   = 14'b00000000000100,
      ST_LV1   = 14'b00000000001000,
      ST_LV2   = 14'b00000000010000,
      ST_FETCH = 14'b00000000100000,
      ST_LOAD  = 14'b00000001000000,
      ST_MUP   = 14'b00000010000000,
      ST_WUP   = 14'b00000100000000,
      ST_WMID  = 14'b00001000000000,
      ST_WDN   = 14'b00010000000000,
      ST_FIN0  = 14'b00100000000000,
      ST_FIN1  = 14'b01000000000000,
      ST_FINW  = 14'b10000000000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [PW-1:0]                 strike_ff;
   logic                          put_ff;
   logic [trin_pkg::PROB_W-1:0]   pu_ff, pd_ff, pm_ff;
   logic                          sat_ff, sat_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [AW-1:0]                 last_ff;
   logic [AW-1:0]                 len_ff, len_in;
   logic [PW-1:0]                 w0_ff, w1_ff, w2_ff;
   logic                          done_ff;
   logic [PW-1:0]                 price_ff;
   logic                          ovf_ff;

   trin_pkg::mac_cmd_type         mac_cmd;
   trin_pkg::mac_rsp_type         mac_rsp;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [PW-1:0]                 wr_data;
   logic [AW-1:0]                 rd_addr;
   logic [PW-1:0]                 rd_data;

   logic [CW-1:0]                 steps_ext;
   logic [CW-1:0]                 n_c;
   logic [AW-1:0]                 two_n;
   logic [trin_pkg::PROB_W-1:0]   pu_c, pd_c, disc_c;
   logic [trin_pkg::PROB_W:0]     p_sum;
   logic                          red_sat;
   logic [PW-1:0]                 red_val;
   logic [PW-1:0]                 payoff;

   trin_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trin_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .rsp   (mac_rsp)
   );

   // item set-up: clamp steps, probabilities and the discount factor
   always_comb begin
      steps_ext = CW'(cfg.num_steps);
      n_c       = (steps_ext > CW'(MAX_STEPS)) ? CW'(MAX_STEPS) : steps_ext;
      two_n     = AW'(n_c) << 1;
      pu_c      = (cfg.prob_up > trin_pkg::ONE_Q32) ? trin_pkg::ONE_Q32 : cfg.prob_up;
      pd_c      = (cfg.prob_down > trin_pkg::ONE_Q32) ? trin_pkg::ONE_Q32 : cfg.prob_down;
      disc_c    = (cfg.discount_factor > trin_pkg::ONE_Q32) ? trin_pkg::ONE_Q32
                                                             : cfg.discount_factor;
      p_sum     = {1'b0, pu_c} + {1'b0, pd_c};
   end

   // round (already in the sum), shift by 32, saturate
   always_comb begin
      red_sat = |mac_rsp.acc[95:80];
      red_val = red_sat ? {PW{1'b1}} : mac_rsp.acc[79:32];
      if (put_ff) begin
         payoff = (strike_ff > red_val) ? strike_ff - red_val : '0;
      end else begin
         payoff = (red_val > strike_ff) ? red_val - strike_ff : '0;
      end
   end

   // next state, memory and multiplier commands
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      sat_in        = sat_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = red_val;
      rd_addr       = '0;
      mac_cmd.go    = 1'b0;
      mac_cmd.clear = 1'b1;
      mac_cmd.a     = '0;
      mac_cmd.b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mac_cmd.go = 1'b1;
               mac_cmd.a  = forward_price;
               mac_cmd.b  = cfg.lowest_node_factor;
               idx_in     = '0;
               len_in     = two_n - AW'(1);
               sat_in     = p_sum > {1'b0, trin_pkg::ONE_Q32};
               state_in   = ST_FILL;
            end
         end
         ST_FILL: begin
            if (mac_rsp.done) begin
               sat_in  = sat_ff | red_sat;
               wr_en   = 1'b1;
               wr_data = payoff;
               if (idx_ff == last_ff) begin
                  idx_in   = '0;
                  state_in = (last_ff == '0) ? ST_FIN0 : ST_LV0;
               end else begin
                  idx_in     = idx_ff + AW'(1);
                  mac_cmd.go = 1'b1;
                  mac_cmd.a  = red_val;
                  mac_cmd.b  = cfg.up_factor;
               end
            end
         end
         ST_LV0: begin
            rd_addr  = '0;
            state_in = ST_LV1;
         end
         ST_LV1: begin
            rd_addr  = AW'(1);
            state_in = ST_LV2;
         end
         ST_LV2: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            rd_addr  = idx_ff + AW'(2);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_MUP;
         end
         ST_MUP: begin
            mac_cmd.go = 1'b1;
            mac_cmd.a  = w2_ff;
            mac_cmd.b  = {7'b0, pu_ff};
            state_in   = ST_WUP;
         end
         ST_WUP: begin
            if (mac_rsp.done) begin
               mac_cmd.go    = 1'b1;
               mac_cmd.clear = 1'b0;
               mac_cmd.a     = w1_ff;
               mac_cmd.b     = {7'b0, pm_ff};
               state_in      = ST_WMID;
            end
         end
         ST_WMID: begin
            if (mac_rsp.done) begin
               mac_cmd.go    = 1'b1;
               mac_cmd.clear = 1'b0;
               mac_cmd.a     = w0_ff;
               mac_cmd.b     = {7'b0, pd_ff};
               state_in      = ST_WDN;
            end
         end
         ST_WDN: begin
            if (mac_rsp.done) begin
               sat_in = sat_ff | red_sat;
               wr_en  = 1'b1;
               if (idx_ff == len_ff - AW'(1)) begin
                  idx_in = '0;
                  if (len_ff == AW'(1)) begin
                     state_in = ST_FIN0;
                  end else begin
                     len_in   = len_ff - AW'(2);
                     state_in = ST_LV0;
                  end
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FIN0: begin
            rd_addr  = '0;
            state_in = ST_FIN1;
         end
         ST_FIN1: begin
            mac_cmd.go = 1'b1;
            mac_cmd.a  = rd_data;
            mac_cmd.b  = {7'b0, disc_c};
            state_in   = ST_FINW;
         end
         ST_FINW: begin
            if (mac_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == ST_FINW) && mac_rsp.done;
      end
   end

   // item payload, counters and the three-node window
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      sat_ff <= sat_in;
      if (state_ff == ST_IDLE && start) begin
         strike_ff <= strike_price;
         put_ff    <= option_kind;
         pu_ff     <= pu_c;
         pd_ff     <= pd_c;
         pm_ff     <= (p_sum > {1'b0, trin_pkg::ONE_Q32}) ? '0
                      : trin_pkg::PROB_W'({1'b0, trin_pkg::ONE_Q32} - p_sum);
         last_ff   <= two_n;
      end
      if (state_ff == ST_LV1) begin
         w0_ff <= rd_data;
      end
      if (state_ff == ST_LV2) begin
         w1_ff <= rd_data;
      end
      if (state_ff == ST_LOAD) begin
         w2_ff <= rd_data;
      end
      // slide the window after a node is written
      if (state_ff == ST_WDN && mac_rsp.done) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
      end
      if (state_ff == ST_FINW && mac_rsp.done) begin
         price_ff <= red_val;
         ovf_ff   <= sat_ff | red_sat;
      end
   end

   assign busy         = state_ff != ST_IDLE;
   assign done         = done_ff;
   assign option_price = price_ff;
   assign overflow     = ovf_ff;

endmodule

`default_nettype wire
